>>> rtl/mcb_pkg.sv
// Shared types, codes and constants of the Modbus coil bank.
`timescale 1ns / 1ps
`default_nettype none

package mcb_pkg;

    // Default and limits of the coil bank size
    localparam int MAX_COILS_DEF = 256;
    localparam int ROW_W_DEF     = 5;

    // Port widths
    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;
    localparam int CC_W       = 9;

    // Field widths
    localparam int QTY_W  = 11;
    localparam int STAT_W = 2;
    localparam int BC_W   = 6;
    localparam int CNT_W  = 5;

    localparam logic [8:0]  COIL_COUNT_RST = 9'd256;
    localparam logic [15:0] QTY_LIMIT      = 16'h07D0;
    localparam logic [7:0]  COIL_ON        = 8'hFF;
    localparam logic [7:0]  COIL_OFF       = 8'h00;

    // Request commands
    localparam logic [1:0] CMD_READ    = 2'd0;
    localparam logic [1:0] CMD_WSINGLE = 2'd1;
    localparam logic [1:0] CMD_WMULTI  = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    // Response status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_QTY  = 2'd1;
    localparam logic [1:0] STAT_ADDR = 2'd2;

    // Operation kinds handed from front to back
    localparam logic [1:0] K_REJ   = 2'd0;
    localparam logic [1:0] K_READ  = 2'd1;
    localparam logic [1:0] K_WRITE = 2'd2;

    // Classified operation; the row index travels beside it
    typedef struct packed {
        logic [1:0]       kind;
        logic [1:0]       status;
        logic [2:0]       off;
        logic [7:0]       mask;
        logic [7:0]       data;
        logic [QTY_W-1:0] qty;
    } mcb_op_t;

endpackage

`default_nettype wire

>>> rtl/modbus_coil_bank_unit.sv
// Modbus coil bank: read coils, write single coil and write multiple coil chunks.
//
// The front end checks each request word in the cycle it arrives and places it in a
// two-entry queue, so words are taken every cycle while the queue has room; command 3
// words are taken and dropped. The back end executes one queued operation at a time
// against a coil memory of (MAX_COILS+7)/8 rows with per-row valid bits, so there is
// no clearing pass after reset. A rejected request gives its single word through the output
// register. A write (single coil or multiple chunk) reads both rows of the coil window,
// writes the low row, then writes the high row with the reply; a read issues a memory
// read and then packs, once per returned byte. This sequence is set by the single memory
// write port and the registered read.
// Output words wait in a register and the back end stalls while it is full.
`timescale 1ns / 1ps
`default_nettype none

module modbus_coil_bank_unit #(
    parameter int MAX_COILS = mcb_pkg::MAX_COILS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           coil_count_we,
    input  wire logic [mcb_pkg::CC_W-1:0]       coil_count_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // start_address[15:0], quantity[31:16], coil_value[39:32], data_byte[47:40],
    // byte_number[55:48]
    input  wire logic [mcb_pkg::IN_DATA_W-1:0]  s_tdata,
    // cmd[1:0]
    input  wire logic [mcb_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // status[1:0], read_byte[9:2], byte_count[15:10]
    output logic [mcb_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);
    import mcb_pkg::*;

    localparam int STORE_BYTES = (MAX_COILS + 7) / 8;
    localparam int ROW_W       = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    mcb_op_t          f_op;
    logic [ROW_W-1:0] f_row;
    logic             f_push;
    logic             q_full;
    mcb_op_t          q_op;
    logic [ROW_W-1:0] q_row;
    logic             q_valid;
    logic             q_pop;

    mcb_front #(
        .MAX_COILS (MAX_COILS),
        .ROW_W     (ROW_W)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .coil_count_we    (coil_count_we),
        .coil_count_wdata (coil_count_wdata),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .full             (q_full),
        .push             (f_push),
        .op               (f_op),
        .row              (f_row)
    );

    mcb_queue #(
        .ROW_W (ROW_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (f_push),
        .op_in   (f_op),
        .row_in  (f_row),
        .full    (q_full),
        .pop     (q_pop),
        .q_valid (q_valid),
        .op_out  (q_op),
        .row_out (q_row)
    );

    mcb_back #(
        .MAX_COILS (MAX_COILS),
        .ROW_W     (ROW_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .op       (q_op),
        .row      (q_row),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

>>> rtl/mcb_front.sv
// Request front end: coil_count register, request checks and write mask setup.
`timescale 1ns / 1ps
`default_nettype none

module mcb_front #(
    parameter int MAX_COILS = mcb_pkg::MAX_COILS_DEF,
    parameter int ROW_W     = mcb_pkg::ROW_W_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          coil_count_we,
    input  wire logic [mcb_pkg::CC_W-1:0]      coil_count_wdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [mcb_pkg::IN_DATA_W-1:0] s_tdata,
    input  wire logic [mcb_pkg::IN_USER_W-1:0] s_tuser,
    input  wire logic                          full,
    output logic                               push,
    output mcb_pkg::mcb_op_t                   op,
    output logic [ROW_W-1:0]                   row
);
    import mcb_pkg::*;

    localparam int CW = $clog2(MAX_COILS + 1);
    localparam int UW = (CW > CC_W) ? CW : CC_W;

    logic [CC_W-1:0] coil_count_reg;
    logic [UW-1:0]   cc_ext;
    logic [UW-1:0]   max_ext;
    logic [UW-1:0]   used;
    logic [16:0]     used17;
    logic [1:0]      cmd;
    logic [15:0]     start;
    logic [15:0]     qty;
    logic [7:0]      cval;
    logic [7:0]      dbyte;
    logic [7:0]      bnum;
    logic [16:0]     sum17;
    logic [15:0]     row16;
    logic [15:0]     row_mul;
    logic [15:0]     bn8;
    logic [15:0]     remm;
    logic [7:0]      mmask;
    logic            qty_bad;

    // Coil count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coil_count_reg <= COIL_COUNT_RST;
        end
        else if (coil_count_we)
        begin
            coil_count_reg <= coil_count_wdata;
        end
    end

    // Coils in use, limited to the bank size
    assign cc_ext  = UW'(coil_count_reg);
    assign max_ext = UW'(MAX_COILS);
    assign used    = (cc_ext > max_ext) ? max_ext : cc_ext;
    assign used17  = 17'(used);

    // Word fields
    assign cmd   = s_tuser;
    assign start = s_tdata[15:0];
    assign qty   = s_tdata[31:16];
    assign cval  = s_tdata[39:32];
    assign dbyte = s_tdata[47:40];
    assign bnum  = s_tdata[55:48];

    assign sum17   = {1'b0, start} + {1'b0, qty};
    assign qty_bad = (qty == 16'd0) || (qty > QTY_LIMIT);

    // Row and mask of a write multiple chunk
    assign row16   = {3'b000, start[15:3]};
    assign row_mul = row16 + {8'h00, bnum};
    assign bn8     = {5'b00000, bnum, 3'b000};
    assign remm    = qty - bn8;
    always_comb
    begin
        if (qty <= bn8)
        begin
            mmask = 8'h00;
        end
        else if (remm >= 16'd8)
        begin
            mmask = 8'hFF;
        end
        else
        begin
            mmask = 8'((9'd1 << remm[2:0]) - 9'd1);
        end
    end

    // Classification
    always_comb
    begin
        op.kind   = K_REJ;
        op.status = STAT_OK;
        op.off    = start[2:0];
        op.mask   = 8'h00;
        op.data   = 8'h00;
        op.qty    = qty[QTY_W-1:0];
        row       = row16[ROW_W-1:0];
        case (cmd)
            CMD_WSINGLE:
            begin
                if (cval != COIL_OFF && cval != COIL_ON)
                begin
                    op.status = STAT_QTY;
                end
                else if (17'(start) >= used17)
                begin
                    op.status = STAT_ADDR;
                end
                else
                begin
                    op.kind = K_WRITE;
                    op.mask = 8'h01;
                    op.data = (cval == COIL_ON) ? 8'hFF : 8'h00;
                end
            end
            CMD_READ, CMD_WMULTI:
            begin
                if (qty_bad)
                begin
                    op.status = STAT_QTY;
                end
                else if (sum17 > used17)
                begin
                    op.status = STAT_ADDR;
                end
                else if (cmd == CMD_READ)
                begin
                    op.kind = K_READ;
                end
                else
                begin
                    op.kind = K_WRITE;
                    op.mask = mmask;
                    op.data = dbyte;
                    row     = row_mul[ROW_W-1:0];
                end
            end
            default:
            begin
                op.kind = K_REJ;
            end
        endcase
    end

    // Unused command words are taken and dropped
    assign s_tready = !full;
    assign push     = s_tvalid && s_tready && (cmd != CMD_NONE);

endmodule

`default_nettype wire

>>> rtl/mcb_queue.sv
// Two-entry operation queue between front end and back end.
`timescale 1ns / 1ps
`default_nettype none

module mcb_queue #(
    parameter int ROW_W = mcb_pkg::ROW_W_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire mcb_pkg::mcb_op_t op_in,
    input  wire logic [ROW_W-1:0] row_in,
    output logic                  full,
    input  wire logic             pop,
    output logic                  q_valid,
    output mcb_pkg::mcb_op_t      op_out,
    output logic [ROW_W-1:0]      row_out
);
    import mcb_pkg::*;

    localparam int DEPTH = 2;

    mcb_op_t          op_mem  [DEPTH];
    logic [ROW_W-1:0] row_mem [DEPTH];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == 2'(DEPTH));
    assign q_valid = (cnt_reg != 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;
    assign op_out  = op_mem[rd_ptr_reg];
    assign row_out = row_mem[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            op_mem[wr_ptr_reg]  <= op_in;
            row_mem[wr_ptr_reg] <= row_in;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/mcb_back.sv
// Back end: coil memory, read packing, read-modify-write and output register.
`timescale 1ns / 1ps
`default_nettype none

module mcb_back #(
    parameter int MAX_COILS = mcb_pkg::MAX_COILS_DEF,
    parameter int ROW_W     = mcb_pkg::ROW_W_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           q_valid,
    input  wire mcb_pkg::mcb_op_t               op,
    input  wire logic [ROW_W-1:0]               row,
    output logic                                pop,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [mcb_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);
    import mcb_pkg::*;

    localparam int STORE_BYTES = (MAX_COILS + 7) / 8;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_RD_ISSUE = 3'd1;
    localparam logic [2:0] S_RD_DATA  = 3'd2;
    localparam logic [2:0] S_WR_ISSUE = 3'd3;
    localparam logic [2:0] S_WR_LO    = 3'd4;
    localparam logic [2:0] S_WR_HI    = 3'd5;

    // Coil memory, one row of eight coils per entry
    logic [7:0]             coil_mem [STORE_BYTES];
    logic [STORE_BYTES-1:0] vld_reg;
    logic [7:0]             rd_lo_reg;
    logic [7:0]             rd_hi_reg;
    logic                   rd_lo_v_reg;
    logic                   rd_hi_v_reg;

    logic [2:0]       state_reg, state_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [2:0]       off_reg, off_next;
    logic [7:0]       mask_reg, mask_next;
    logic [7:0]       data_reg, data_next;
    logic [QTY_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [BC_W-1:0]  bc_reg, bc_next;

    logic              out_valid_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic [7:0]        out_byte_reg;
    logic [BC_W-1:0]   out_bc_reg;
    logic              out_last_reg;

    logic              out_free;
    logic              out_load;
    logic [STAT_W-1:0] out_status;
    logic [7:0]        out_byte;
    logic [BC_W-1:0]   out_bc;
    logic              out_last;

    logic [ROW_W:0]   hi_ext;
    logic             hi_in;
    logic [ROW_W-1:0] hi_idx;
    logic [7:0]       lo_byte;
    logic [7:0]       hi_byte;
    logic [15:0]      pair_sh;
    logic [7:0]       rd_mask;
    logic [7:0]       rd_byte;
    logic             rd_last;
    logic [15:0]      wmask16;
    logic [15:0]      wdata16;
    logic [7:0]       new_lo;
    logic [7:0]       new_hi;
    logic [11:0]      nbytes;
    logic             we;
    logic [ROW_W-1:0] waddr;
    logic [7:0]       wdata;

    // Second row of a coil window, if it exists
    assign hi_ext = {1'b0, row_reg} + {{ROW_W{1'b0}}, 1'b1};
    assign hi_in  = (hi_ext < (ROW_W + 1)'(STORE_BYTES));
    assign hi_idx = hi_in ? hi_ext[ROW_W-1:0] : '0;

    // Memory write port and two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            coil_mem[waddr] <= wdata;
        end
        rd_lo_reg   <= coil_mem[row_reg];
        rd_hi_reg   <= coil_mem[hi_idx];
        rd_lo_v_reg <= vld_reg[row_reg];
        rd_hi_v_reg <= hi_in && vld_reg[hi_idx];
    end

    // Row valid bits; an unwritten row reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (we)
        begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    assign lo_byte = rd_lo_v_reg ? rd_lo_reg : 8'h00;
    assign hi_byte = rd_hi_v_reg ? rd_hi_reg : 8'h00;

    // Read packing: window shift and quantity mask
    assign pair_sh = {hi_byte, lo_byte} >> off_reg;
    always_comb
    begin
        if (rem_reg >= QTY_W'(8))
        begin
            rd_mask = 8'hFF;
        end
        else
        begin
            rd_mask = 8'((9'd1 << rem_reg[2:0]) - 9'd1);
        end
    end
    assign rd_byte = pair_sh[7:0] & rd_mask;
    assign rd_last = (rem_reg <= QTY_W'(8)) || (cnt_reg == {CNT_W{1'b1}});

    // Write merge over the two rows
    assign wmask16 = {8'h00, mask_reg} << off_reg;
    assign wdata16 = {8'h00, data_reg} << off_reg;
    assign new_lo  = (lo_byte & ~wmask16[7:0]) | (wdata16[7:0] & wmask16[7:0]);
    assign new_hi  = (hi_byte & ~wmask16[15:8]) | (wdata16[15:8] & wmask16[15:8]);

    assign nbytes   = (12'(op.qty) + 12'd7) >> 3;
    assign out_free = !out_valid_reg || m_tready;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        off_next   = off_reg;
        mask_next  = mask_reg;
        data_next  = data_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        bc_next    = bc_reg;
        pop        = 1'b0;
        we         = 1'b0;
        waddr      = row_reg;
        wdata      = new_lo;
        out_load   = 1'b0;
        out_status = STAT_OK;
        out_byte   = 8'h00;
        out_bc     = '0;
        out_last   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (op.kind == K_REJ)
                    begin
                        if (out_free)
                        begin
                            pop        = 1'b1;
                            out_load   = 1'b1;
                            out_status = op.status;
                        end
                    end
                    else
                    begin
                        pop        = 1'b1;
                        row_next   = row;
                        off_next   = op.off;
                        mask_next  = op.mask;
                        data_next  = op.data;
                        rem_next   = op.qty;
                        cnt_next   = '0;
                        bc_next    = nbytes[BC_W-1:0];
                        state_next = (op.kind == K_READ) ? S_RD_ISSUE : S_WR_ISSUE;
                    end
                end
            end
            S_RD_ISSUE:
            begin
                state_next = S_RD_DATA;
            end
            S_RD_DATA:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    out_byte = rd_byte;
                    out_bc   = bc_reg;
                    out_last = rd_last;
                    if (rd_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + ROW_W'(1);
                        rem_next   = rem_reg - QTY_W'(8);
                        cnt_next   = cnt_reg + CNT_W'(1);
                        state_next = S_RD_ISSUE;
                    end
                end
            end
            S_WR_ISSUE:
            begin
                state_next = S_WR_LO;
            end
            S_WR_LO:
            begin
                we         = (wmask16[7:0] != 8'h00);
                state_next = S_WR_HI;
            end
            S_WR_HI:
            begin
                if (out_free)
                begin
                    we         = (wmask16[15:8] != 8'h00) && hi_in;
                    waddr      = hi_idx;
                    wdata      = new_hi;
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Working registers of the current operation
    always_ff @(posedge clk)
    begin
        row_reg  <= row_next;
        off_reg  <= off_next;
        mask_reg <= mask_next;
        data_reg <= data_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        bc_reg   <= bc_next;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= out_status;
            out_byte_reg   <= out_byte;
            out_bc_reg     <= out_bc;
            out_last_reg   <= out_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_bc_reg, out_byte_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

>>> rtl/mcb_checker.sv
// Port-level checks of the coil bank output stream, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mcb_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [mcb_pkg::OUT_DATA_W-1:0] m_tdata,
    input wire logic                           m_tlast
);
    import mcb_pkg::*;

    // A stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // An error reply is a single bare word
    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] != STAT_OK) |-> (m_tdata[15:2] == 14'd0) && m_tlast)
        else $error("error reply carries data or is not last");

    // Only read replies span several words, and they carry a byte count
    a_multi_read: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> (m_tdata[1:0] == STAT_OK) && (m_tdata[15:10] != 6'd0))
        else $error("non-last word is not part of a read reply");

    // Within a read reply the byte count stays the same from word to word
    a_bc_same: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast ##1 m_tvalid
            |-> m_tdata[15:10] == $past(m_tdata[15:10]))
        else $error("byte count changed within a read reply");

endmodule

bind modbus_coil_bank_unit mcb_checker u_mcb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
